### rtl/core/hough_layer_vote_merge_top_defines.svh
// ----------------------------------------------------------------------------
// Hough layer vote merge: assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef HOUGH_LAYER_VOTE_MERGE_TOP_DEFINES_SVH
`define HOUGH_LAYER_VOTE_MERGE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLVM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HLVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hlvm_pkg.sv
// ----------------------------------------------------------------------------
// Hough layer vote merge package
// Sizes, command and register codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package hlvm_pkg;

    localparam int NUM_LAYERS    = 8;
    localparam int NUM_WORDS     = 128;
    localparam int BITS_PER_WORD = 32;

    localparam int COUNT_W   = 8;
    localparam int LAYER_W   = $clog2(NUM_LAYERS);
    localparam int WORD_W    = $clog2(NUM_WORDS);
    localparam int COL_W     = $clog2(BITS_PER_WORD);
    localparam int CELL_W    = WORD_W + COL_W;
    localparam int ROW_W     = BITS_PER_WORD * COUNT_W;
    localparam int LCOUNT_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ACCUM = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_LAYER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAYERS_USED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_FIRST   = 2'd2;

    typedef struct packed {
        logic [NUM_LAYERS-1:0] layer_enable;
        logic [LCOUNT_W-1:0]   layers_in_use;
        logic                  skip_first_layer;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic wr_en;
        logic clr;
        logic capture;
    } ctrl_cmd_t;

    typedef struct packed {
        logic accum_ok;
        logic is_clear;
        logic is_read;
    } dp_status_t;

endpackage

### rtl/core/hough_layer_vote_merge_top.sv
// ----------------------------------------------------------------------------
// Hough layer vote merge
// Merges per-layer 32-cell hit words into a plane of 4096 saturating 8-bit
// vote counters. A command is taken on start while busy is low: accumulate
// adds one to each hit cell of an accepted layer, clear zeroes all counters,
// read returns one counter on cell_count with a one-cycle done strobe.
// An accumulate of an accepted layer passes through row fetch, registered
// read and write-back; a rejected one, a clear and an unused command end
// after the fetch state. For a read, done is high in the first cycle that
// busy is low again. One command is in flight at a time. The configuration
// channel is always ready; the user must write it only while the block is
// idle, which the block does not enforce. Reset sets the registers to their
// defaults and marks every counter row as zero at once. The receiver cannot
// stall: each result is a transfer that lasts exactly one cycle.
// ----------------------------------------------------------------------------
`include "hough_layer_vote_merge_top_defines.svh"

module hough_layer_vote_merge_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic [hlvm_pkg::LAYER_W-1:0]        layer,
    input  logic [hlvm_pkg::WORD_W-1:0]         word_index,
    input  logic [hlvm_pkg::BITS_PER_WORD-1:0]  hit_bits,
    input  logic [hlvm_pkg::CELL_W-1:0]         cell_index,
    output logic                                done,
    output logic [hlvm_pkg::COUNT_W-1:0]        cell_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hlvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hlvm_pkg::CFG_DAT_W-1:0]      cfg_data
);
    import hlvm_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LAYER_ENABLE: cfg_next.layer_enable     = cfg_data[NUM_LAYERS-1:0];
                REG_LAYERS_USED:  cfg_next.layers_in_use    = cfg_data[LCOUNT_W-1:0];
                REG_SKIP_FIRST:   cfg_next.skip_first_layer = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.layer_enable     <= '0;
            cfg_reg.layers_in_use    <= LCOUNT_W'(NUM_LAYERS);
            cfg_reg.skip_first_layer <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hlvm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .cmd    (ctrl_cmd),
        .busy   (busy),
        .done   (done)
    );

    hlvm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .cfg        (cfg_reg),
        .cmd_code   (cmd),
        .layer      (layer),
        .word_index (word_index),
        .hit_bits   (hit_bits),
        .cell_index (cell_index),
        .status     (dp_status),
        .cell_count (cell_count)
    );

    `HLVM_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy, "accepted command did not raise busy")
    `HLVM_ASSERT_SAME(a_done_after_busy, done, $past(busy) && !busy, "done without a finished command")
    `HLVM_ASSERT_SAME(a_no_write_and_clear, ctrl_cmd.wr_en, !ctrl_cmd.clr && busy, "row write clashes with clear")

endmodule

### rtl/core/hlvm_ctrl.sv
// ----------------------------------------------------------------------------
// Hough layer vote merge controller
// Sequences each command: row fetch and write-back for an accumulate, row fetch and capture for a read, and the clear.
// ----------------------------------------------------------------------------
module hlvm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  hlvm_pkg::dp_status_t status,
    output hlvm_pkg::ctrl_cmd_t  cmd,
    output logic                busy,
    output logic                done
);
    import hlvm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_FETCH  = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (status.accum_ok || status.is_read)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cmd.clr    = status.is_clear;
                    state_next = ST_IDLE;
                end
            end
            ST_UPDATE:
            begin
                cmd.wr_en   = status.accum_ok;
                cmd.capture = status.is_read;
                done_next   = status.is_read;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

### rtl/core/hlvm_dp.sv
// ----------------------------------------------------------------------------
// Hough layer vote merge datapath
// Holds the counter memory, row valid bits, item registers and the
// 32-lane saturating increment.
// ----------------------------------------------------------------------------
module hlvm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hlvm_pkg::ctrl_cmd_t                 cmd,
    input  hlvm_pkg::cfg_t                      cfg,
    input  logic [1:0]                          cmd_code,
    input  logic [hlvm_pkg::LAYER_W-1:0]        layer,
    input  logic [hlvm_pkg::WORD_W-1:0]         word_index,
    input  logic [hlvm_pkg::BITS_PER_WORD-1:0]  hit_bits,
    input  logic [hlvm_pkg::CELL_W-1:0]         cell_index,
    output hlvm_pkg::dp_status_t                status,
    output logic [hlvm_pkg::COUNT_W-1:0]        cell_count
);
    import hlvm_pkg::*;

    logic [1:0]               cmd_reg;
    logic [LAYER_W-1:0]       layer_reg;
    logic [WORD_W-1:0]        word_reg;
    logic [BITS_PER_WORD-1:0] hits_reg;
    logic [CELL_W-1:0]        cell_reg;

    logic [ROW_W-1:0]         vote_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]     valid_reg;
    logic [NUM_WORDS-1:0]     valid_next;
    logic [ROW_W-1:0]         rd_row_reg;
    logic                     rd_valid_reg;
    logic [COUNT_W-1:0]       cell_count_reg;

    logic [WORD_W-1:0]        rd_addr;
    logic [ROW_W-1:0]         upd_row;
    logic                     layer_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= cmd_code;
            layer_reg <= layer;
            word_reg  <= word_index;
            hits_reg  <= hit_bits;
            cell_reg  <= cell_index;
        end
    end

    assign layer_ok = cfg.layer_enable[layer_reg]
                   && ({1'b0, layer_reg} < cfg.layers_in_use)
                   && !((layer_reg == '0) && cfg.skip_first_layer);

    assign status.accum_ok = (cmd_reg == CMD_ACCUM) && layer_ok;
    assign status.is_clear = (cmd_reg == CMD_CLEAR);
    assign status.is_read  = (cmd_reg == CMD_READ);

    assign rd_addr = (cmd_reg == CMD_READ) ? cell_reg[CELL_W-1:COL_W] : word_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            vote_mem[word_reg] <= upd_row;
        end
        if (cmd.rd_en)
        begin
            rd_row_reg   <= vote_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // A row that has not been written since reset or the last clear reads as zero.
    always_comb
    begin
        logic [COUNT_W-1:0] cnt;
        for (int k = 0; k < BITS_PER_WORD; k++)
        begin
            cnt = rd_valid_reg ? rd_row_reg[k*COUNT_W +: COUNT_W] : '0;
            if (hits_reg[k] && (cnt != COUNT_MAX))
            begin
                cnt = cnt + COUNT_W'(1);
            end
            upd_row[k*COUNT_W +: COUNT_W] = cnt;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        priority if (cmd.clr)
        begin
            valid_next = '0;
        end
        else if (cmd.wr_en)
        begin
            valid_next[word_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cell_count_reg <= rd_valid_reg
                            ? rd_row_reg[cell_reg[COL_W-1:0]*COUNT_W +: COUNT_W]
                            : '0;
        end
    end

    assign cell_count = cell_count_reg;

endmodule

### sim/tb_hough_layer_vote_merge_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hough layer vote merge testbench
// Drives accumulate, clear, read and unused commands through the start/busy
// handshake and sets the layer registers between phases. A behavioural copy
// of the vote plane predicts every read, and each done strobe is checked
// against the oldest outstanding read. The directed opening covers layer
// acceptance and word extremes. The random part first drives one word into
// saturation and then runs mixed traffic under several register settings.
// ----------------------------------------------------------------------------

import hlvm_pkg::*;

typedef struct packed {
    logic [CELL_W-1:0]  cell_id;
    logic [COUNT_W-1:0] count;
} pending_read_t;

class vote_plane_model;

    bit [COUNT_W-1:0]    counts [0:NUM_WORDS*BITS_PER_WORD-1];
    bit [NUM_LAYERS-1:0] layer_enable;
    bit [LCOUNT_W-1:0]   layers_in_use;
    bit                  skip_first;
    pending_read_t       reads_due [$];
    int errors;
    int merged_words;
    int ignored_words;
    int clears;
    int reads_checked;
    int full_reads;

    function new();
        foreach (counts[i])
            counts[i] = '0;
        layer_enable  = '0;
        layers_in_use = 4'd8;
        skip_first    = 1'b0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_LAYER_ENABLE: layer_enable  = data[NUM_LAYERS-1:0];
            REG_LAYERS_USED:  layers_in_use = data[LCOUNT_W-1:0];
            REG_SKIP_FIRST:   skip_first    = data[0];
            default: ;
        endcase
    endfunction

    function bit layer_merged(logic [LAYER_W-1:0] lay);
        if (lay >= layers_in_use)
            return 1'b0;
        if (lay == 0 && skip_first)
            return 1'b0;
        return layer_enable[lay];
    endfunction

    function int pending();
        return reads_due.size();
    endfunction

    function void note_command(logic [1:0] c, logic [LAYER_W-1:0] lay,
                               logic [WORD_W-1:0] w, logic [BITS_PER_WORD-1:0] hits,
                               logic [CELL_W-1:0] cell_idx);
        pending_read_t rd;
        if (c == CMD_ACCUM)
        begin
            if (layer_merged(lay))
            begin
                merged_words++;
                for (int k = 0; k < BITS_PER_WORD; k++)
                    if (hits[k] && counts[{w, k[COL_W-1:0]}] != COUNT_MAX)
                        counts[{w, k[COL_W-1:0]}]++;
            end
            else
                ignored_words++;
        end
        else if (c == CMD_CLEAR)
        begin
            clears++;
            foreach (counts[i])
                counts[i] = '0;
        end
        else if (c == CMD_READ)
        begin
            rd.cell_id = cell_idx;
            rd.count   = counts[cell_idx];
            reads_due.push_back(rd);
        end
    endfunction

    function void check_count(logic [COUNT_W-1:0] got);
        pending_read_t rd;
        if (reads_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: cell_count %0d arrived with no read outstanding", got);
            return;
        end
        rd = reads_due.pop_front();
        reads_checked++;
        if (rd.count == COUNT_MAX)
            full_reads++;
        if (got !== rd.count)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: cell %0d expected count %0d, got %0d",
                         rd.cell_id, rd.count, got);
        end
    endfunction

endclass

module tb_hough_layer_vote_merge_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               cmd;
    logic [LAYER_W-1:0]       layer;
    logic [WORD_W-1:0]        word_index;
    logic [BITS_PER_WORD-1:0] hit_bits;
    logic [CELL_W-1:0]        cell_index;
    logic                     done;
    logic [COUNT_W-1:0]       cell_count;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DAT_W-1:0]     cfg_data;

    vote_plane_model   plane = new();
    logic [WORD_W-1:0] hot_word;
    int                issued;

    hough_layer_vote_merge_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .layer      (layer),
        .word_index (word_index),
        .hit_bits   (hit_bits),
        .cell_index (cell_index),
        .done       (done),
        .cell_count (cell_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("Timeout with %0d reads still outstanding", plane.pending());
        $display("tb_hough_layer_vote_merge_top: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            plane.check_count(cell_count);
    end

    task automatic issue(input logic [1:0] c, input logic [LAYER_W-1:0] lay,
                         input logic [WORD_W-1:0] w, input logic [BITS_PER_WORD-1:0] hits,
                         input logic [CELL_W-1:0] cell_idx);
        start      <= 1'b1;
        cmd        <= c;
        layer      <= lay;
        word_index <= w;
        hit_bits   <= hits;
        cell_index <= cell_idx;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        plane.note_command(c, lay, w, hits, cell_idx);
        issued++;
    endtask

    task automatic issue_noise(input logic [1:0] c);
        issue(c, LAYER_W'($urandom), WORD_W'($urandom), $urandom, CELL_W'($urandom));
    endtask

    task automatic read_cell(input logic [CELL_W-1:0] cell_idx);
        issue(CMD_READ, LAYER_W'($urandom), WORD_W'($urandom), $urandom, cell_idx);
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (plane.pending() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        plane.set_register(idx, data);
    endtask

    task automatic set_config(input logic [7:0] en, input logic [3:0] lcount, input logic skip);
        logic [7:0] noise;
        noise = 8'($urandom);
        drain();
        write_cfg(REG_LAYER_ENABLE, en);
        write_cfg(REG_LAYERS_USED, {noise[7:4], lcount});
        write_cfg(REG_SKIP_FIRST, {noise[6:0], skip});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item(input bit hammer, input bit gaps);
        int                       r;
        logic [1:0]               c;
        logic [WORD_W-1:0]        w;
        logic [BITS_PER_WORD-1:0] hits;
        logic [CELL_W-1:0]        cell_idx;
        if (gaps && $urandom_range(0, 99) < 20)
            idle_gap($urandom_range(1, 6));
        r        = $urandom_range(0, 99);
        w        = WORD_W'($urandom_range(0, NUM_WORDS - 1));
        hits     = $urandom;
        cell_idx = CELL_W'($urandom_range(0, NUM_WORDS * BITS_PER_WORD - 1));
        if (hammer)
        begin
            c        = (r < 88) ? CMD_ACCUM : (r < 98) ? CMD_READ : CMD_UNUSED;
            w        = hot_word;
            cell_idx = {hot_word, COL_W'($urandom_range(0, BITS_PER_WORD - 1))};
            if ($urandom_range(0, 9) < 8)
                hits = '1;
        end
        else
        begin
            c = (r < 58) ? CMD_ACCUM : (r < 90) ? CMD_READ : (r < 94) ? CMD_CLEAR : CMD_UNUSED;
            if ($urandom_range(0, 1))
                w = hot_word;
            if ($urandom_range(0, 9) < 6)
                cell_idx = {hot_word, COL_W'($urandom_range(0, BITS_PER_WORD - 1))};
            r = $urandom_range(0, 99);
            if (r < 15)
                hits = '1;
            else if (r < 25)
                hits = '0;
        end
        issue(c, LAYER_W'($urandom), w, hits, cell_idx);
    endtask

    task automatic run_phase(input logic [7:0] en, input logic [3:0] lcount, input logic skip,
                             input int n, input bit hammer, input bit gaps);
        set_config(en, lcount, skip);
        hot_word = WORD_W'($urandom_range(0, NUM_WORDS - 1));
        repeat (n) random_item(hammer, gaps);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        cmd        <= CMD_ACCUM;
        layer      <= '0;
        word_index <= '0;
        hit_bits   <= '0;
        cell_index <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_LAYER_ENABLE;
        cfg_data   <= '0;
        issued = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_ACCUM, 3'd1, 7'd3, '1, '0);
        read_cell(12'd101);
        issue_noise(CMD_UNUSED);

        set_config(8'hFF, 4'd8, 1'b0);
        issue(CMD_ACCUM, 3'd0, 7'd0, '1, '0);
        issue(CMD_ACCUM, 3'd7, 7'd127, '1, '1);
        issue(CMD_ACCUM, 3'd3, 7'd5, 32'h8000_0001, '0);
        issue(CMD_ACCUM, 3'd2, 7'd5, '0, '0);
        read_cell(12'd0);
        read_cell(12'd31);
        read_cell(12'd4095);
        read_cell(12'd4064);
        read_cell(12'd160);
        read_cell(12'd191);
        read_cell(12'd161);
        issue_noise(CMD_UNUSED);
        read_cell(12'd0);
        issue_noise(CMD_CLEAR);
        read_cell(12'd0);
        read_cell(12'd4095);

        set_config(8'hFF, 4'd0, 1'b0);
        issue(CMD_ACCUM, 3'd0, 7'd9, '1, '0);
        read_cell(12'd288);

        set_config(8'h81, 4'd15, 1'b1);
        issue(CMD_ACCUM, 3'd0, 7'd9, '1, '0);
        issue(CMD_ACCUM, 3'd7, 7'd9, '1, '0);
        read_cell(12'd288);

        set_config(8'hFE, 4'd3, 1'b0);
        issue(CMD_ACCUM, 3'd3, 7'd9, '1, '0);
        issue(CMD_ACCUM, 3'd2, 7'd9, '1, '0);
        read_cell(12'd295);

        run_phase(8'hFF, 4'd8, 1'b0, 360, 1'b1, 1'b1);
        run_phase(8'($urandom), 4'($urandom), 1'($urandom), 90, 1'b0, 1'b1);
        run_phase(8'h00, 4'd8, 1'b0, 60, 1'b0, 1'b1);
        run_phase(8'hFF, 4'd15, 1'b1, 100, 1'b0, 1'b0);
        run_phase(8'($urandom), 4'd1, 1'b0, 80, 1'b0, 1'b1);
        run_phase(8'($urandom), 4'($urandom), 1'($urandom), 110, 1'b0, 1'b1);
        drain();

        $display("Issued %0d commands: %0d words merged, %0d words ignored, %0d clears.",
                 issued, plane.merged_words, plane.ignored_words, plane.clears);
        $display("Checked %0d counter reads, %0d of them at the saturation limit.",
                 plane.reads_checked, plane.full_reads);
        if (plane.errors == 0 && plane.pending() == 0)
            $display("tb_hough_layer_vote_merge_top: clean");
        else
        begin
            $display("%0d mismatches, %0d reads left without a result",
                     plane.errors, plane.pending());
            $display("tb_hough_layer_vote_merge_top: errors");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/hlvm_pkg.sv
rtl/core/hlvm_ctrl.sv
rtl/core/hlvm_dp.sv
rtl/core/hough_layer_vote_merge_top.sv
sim/tb_hough_layer_vote_merge_top.sv
